// ----- design/lsrf_pkg.sv -----
// lsrf_pkg: shared types, constants and the crc-8 byte update for the led strip report framer
// no dependencies; imported by lsrf_ctrl, lsrf_datapath and led_strip_report_framer_crc8
`timescale 1ns / 1ps
`default_nettype none

package lsrf_pkg;

    localparam int LED_CAP_DEFAULT = 1024;
    localparam int LEDS_PER_REPORT = 20;

    localparam int LIMIT_W   = 11;
    localparam int CMP_W     = 17;
    localparam int BATCH_W   = 5;
    localparam int POS_W     = 6;
    localparam int STEP_W    = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] REPORT_CMD = 8'h01;
    localparam logic [7:0] END_MARK   = 8'hFF;
    localparam logic [POS_W-1:0] CRC_POS = 6'd63;

    localparam logic OP_COLOR = 1'b0;
    localparam logic OP_END   = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

    typedef struct packed {
        logic [63:0] report_word;
        logic        report_done;
        logic        frame_done;
    } word_t;

    typedef enum logic [3:0] {
        SEL_CMD    = 4'd0,
        SEL_CNT_LO = 4'd1,
        SEL_CNT_HI = 4'd2,
        SEL_GREEN  = 4'd3,
        SEL_RED    = 4'd4,
        SEL_BLUE   = 4'd5,
        SEL_ZERO   = 4'd6,
        SEL_FF     = 4'd7,
        SEL_CRC    = 4'd8
    } byte_sel_t;

    typedef struct packed {
        logic      emit;
        byte_sel_t sel;
        logic      end_frame;
        logic      load_item;
        logic      any_set;
        logic      count_inc;
        logic      batch_inc;
        logic      batch_clr;
        logic      frame_clr;
    } cmd_t;

    typedef struct packed {
        logic byte_ok;
        logic pos_last;
        logic batch_zero;
        logic batch_last;
        logic below_limit;
        logic any_seen;
    } sts_t;

    // msb-first crc-8, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/led_strip_report_framer_crc8.sv -----
// Frames a stream of RGB colours into 64-byte LED strip reports, each closed by a CRC-8
// (poly 0x07, init 0, msb first), and hands them out as eight 64-bit words per report.
// The datapath produces one report byte per clock, except that a top-lane byte waits while a
// completed word sits unaccepted in the output register. An accepted colour emits green, red
// and blue bytes, after the command and count bytes if it is the first colour of a report,
// and the twentieth colour of a report is followed by its CRC. An end item pads and closes an
// open report, then emits the end report. A colour past the LED limit, or an end item with
// no colours in the frame, emits nothing. A new item is taken only once the last one is done.
// Depends on lsrf_pkg, lsrf_ctrl and lsrf_datapath.
`timescale 1ns / 1ps
`default_nettype none

module led_strip_report_framer_crc8 #(
    parameter int LED_CAP = lsrf_pkg::LED_CAP_DEFAULT
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             item_valid,
    output logic                            item_ready,
    input  lsrf_pkg::item_t                 item,
    output logic                            word_valid,
    input  wire                             word_ready,
    output lsrf_pkg::word_t                 word,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [lsrf_pkg::LIMIT_W-1:0]     cfg_data
);
    import lsrf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // the limit register takes a write in any cycle
    assign cfg_ready = 1'b1;

    lsrf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_op    (item.op),
        .sts        (sts),
        .cmd        (cmd)
    );

    lsrf_datapath #(
        .LED_CAP (LED_CAP)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .word       (word),
        .word_valid (word_valid),
        .word_ready (word_ready)
    );

endmodule

`default_nettype wire

// ----- design/lsrf_ctrl.sv -----
// lsrf_ctrl: sequencer that walks the byte order of data and end reports
// depends on lsrf_pkg; drives lsrf_datapath through cmd_t and reads sts_t
`timescale 1ns / 1ps
`default_nettype none

module lsrf_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              item_valid,
    output logic             item_ready,
    input  wire              item_op,
    input  lsrf_pkg::sts_t   sts,
    output lsrf_pkg::cmd_t   cmd
);
    import lsrf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_HDR    = 6'b000010,
        S_COLOR  = 6'b000100,
        S_PAD    = 6'b001000,
        S_ENDHDR = 6'b010000,
        S_PADEND = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                end_pending_reg, end_pending_next;

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        end_pending_next = end_pending_reg;
        item_ready       = 1'b0;
        cmd              = '0;
        cmd.sel          = SEL_ZERO;

        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                step_next  = '0;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (item_op == OP_COLOR)
                    begin
                        cmd.any_set = 1'b1;
                        if (sts.below_limit)
                        begin
                            state_next = sts.batch_zero ? S_HDR : S_COLOR;
                        end
                    end
                    else if (sts.any_seen)
                    begin
                        end_pending_next = 1'b1;
                        state_next       = sts.batch_zero ? S_ENDHDR : S_PAD;
                    end
                end
            end

            S_HDR:
            begin
                cmd.emit = 1'b1;
                case (step_reg)
                    3'd0:    cmd.sel = SEL_CMD;
                    3'd1:    cmd.sel = SEL_CNT_LO;
                    default: cmd.sel = SEL_CNT_HI;
                endcase
                if (sts.byte_ok)
                begin
                    if (step_reg == 3'd2)
                    begin
                        step_next  = '0;
                        state_next = S_COLOR;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end

            S_COLOR:
            begin
                cmd.emit = 1'b1;
                case (step_reg)
                    3'd0:    cmd.sel = SEL_GREEN;
                    3'd1:    cmd.sel = SEL_RED;
                    default: cmd.sel = SEL_BLUE;
                endcase
                if (sts.byte_ok)
                begin
                    if (step_reg == 3'd2)
                    begin
                        step_next     = '0;
                        cmd.count_inc = 1'b1;
                        cmd.batch_inc = 1'b1;
                        state_next    = sts.batch_last ? S_PAD : S_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end

            // pad the open data report with zeros, then its crc
            S_PAD:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = sts.pos_last ? SEL_CRC : SEL_ZERO;
                if (sts.byte_ok && sts.pos_last)
                begin
                    cmd.batch_clr = 1'b1;
                    state_next    = end_pending_reg ? S_ENDHDR : S_IDLE;
                end
            end

            S_ENDHDR:
            begin
                cmd.emit      = 1'b1;
                cmd.end_frame = 1'b1;
                case (step_reg)
                    3'd0:    cmd.sel = SEL_CMD;
                    3'd1:    cmd.sel = SEL_FF;
                    3'd2:    cmd.sel = SEL_FF;
                    3'd3:    cmd.sel = SEL_CNT_LO;
                    default: cmd.sel = SEL_CNT_HI;
                endcase
                if (sts.byte_ok)
                begin
                    if (step_reg == 3'd4)
                    begin
                        step_next  = '0;
                        state_next = S_PADEND;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end

            S_PADEND:
            begin
                cmd.emit      = 1'b1;
                cmd.end_frame = 1'b1;
                cmd.sel       = sts.pos_last ? SEL_CRC : SEL_ZERO;
                if (sts.byte_ok && sts.pos_last)
                begin
                    cmd.frame_clr    = 1'b1;
                    end_pending_next = 1'b0;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next       = S_IDLE;
                step_next        = '0;
                end_pending_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            end_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            end_pending_reg <= end_pending_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/lsrf_datapath.sv -----
// lsrf_datapath: byte lane packer, running crc, led counters, limit register and output word
// depends on lsrf_pkg; commanded by lsrf_ctrl
`timescale 1ns / 1ps
`default_nettype none

module lsrf_datapath #(
    parameter int LED_CAP = lsrf_pkg::LED_CAP_DEFAULT
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  lsrf_pkg::cmd_t                  cmd,
    output lsrf_pkg::sts_t                  sts,
    input  lsrf_pkg::item_t                 item,
    input  wire                             cfg_valid,
    input  wire [lsrf_pkg::LIMIT_W-1:0]     cfg_data,
    output lsrf_pkg::word_t                 word,
    output logic                            word_valid,
    input  wire                             word_ready
);
    import lsrf_pkg::*;

    localparam int CNT_W = $clog2(LED_CAP + 1);

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         crc_reg, crc_next;
    logic [55:0]        pend_reg, pend_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BATCH_W-1:0] batch_reg, batch_next;
    logic               any_reg, any_next;
    logic [7:0]         red_reg, green_reg, blue_reg;
    logic [7:0]         red_next, green_next, blue_next;
    word_t              word_reg, word_next;
    logic               word_valid_reg, word_valid_next;

    logic [2:0]  lane;
    logic        fire;
    logic [7:0]  byte_val;
    logic [15:0] count16;

    assign lane    = pos_reg[2:0];
    assign count16 = 16'(count_reg);

    // a byte in the top lane needs the output slot to be free or leaving
    assign sts.byte_ok     = (lane != 3'd7) || !word_valid_reg || word_ready;
    assign sts.pos_last    = (pos_reg == CRC_POS);
    assign sts.batch_zero  = (batch_reg == '0);
    assign sts.batch_last  = (batch_reg == BATCH_W'(LEDS_PER_REPORT - 1));
    assign sts.below_limit = (CMP_W'(count_reg) < CMP_W'(limit_reg))
                          && (CMP_W'(count_reg) < CMP_W'(LED_CAP));
    assign sts.any_seen    = any_reg;

    assign fire = cmd.emit && sts.byte_ok;

    always_comb
    begin
        case (cmd.sel)
            SEL_CMD:    byte_val = REPORT_CMD;
            SEL_CNT_LO: byte_val = count16[7:0];
            SEL_CNT_HI: byte_val = count16[15:8];
            SEL_GREEN:  byte_val = green_reg;
            SEL_RED:    byte_val = red_reg;
            SEL_BLUE:   byte_val = blue_reg;
            SEL_FF:     byte_val = END_MARK;
            SEL_CRC:    byte_val = crc_reg;
            default:    byte_val = 8'h00;
        endcase
    end

    always_comb
    begin
        limit_next      = limit_reg;
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        pend_next       = pend_reg;
        count_next      = count_reg;
        batch_next      = batch_reg;
        any_next        = any_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        word_next       = word_reg;
        word_valid_next = word_valid_reg;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        if (cmd.load_item)
        begin
            red_next   = item.red;
            green_next = item.green;
            blue_next  = item.blue;
        end

        if (word_ready)
        begin
            word_valid_next = 1'b0;
        end

        if (fire)
        begin
            pos_next = pos_reg + POS_W'(1);
            crc_next = (cmd.sel == SEL_CRC) ? 8'h00 : crc8_byte(crc_reg, byte_val);
            if (lane == 3'd7)
            begin
                word_next.report_word = {byte_val, pend_reg};
                word_next.report_done = sts.pos_last;
                word_next.frame_done  = sts.pos_last && cmd.end_frame;
                word_valid_next       = 1'b1;
                pend_next             = '0;
            end
            else
            begin
                for (int i = 0; i < 7; i++) begin
                    if (lane == 3'(i))
                    begin
                        pend_next[i*8 +: 8] = byte_val;
                    end
                end
            end
        end

        if (cmd.any_set)
        begin
            any_next = 1'b1;
        end
        if (cmd.count_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.batch_inc)
        begin
            batch_next = batch_reg + BATCH_W'(1);
        end
        if (cmd.batch_clr)
        begin
            batch_next = '0;
        end
        if (cmd.frame_clr)
        begin
            count_next = '0;
            batch_next = '0;
            any_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIMIT_RESET;
            pos_reg        <= '0;
            crc_reg        <= '0;
            count_reg      <= '0;
            batch_reg      <= '0;
            any_reg        <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg      <= limit_next;
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            count_reg      <= count_next;
            batch_reg      <= batch_next;
            any_reg        <= any_next;
            word_valid_reg <= word_valid_next;
        end
    end

    // payload only, every lane is written before it is read
    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        word_reg  <= word_next;
    end

    assign word       = word_reg;
    assign word_valid = word_valid_reg;

    a_crc_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (cmd.sel == SEL_CRC) |-> sts.pos_last)
        else $error("crc byte sent away from the last report position");

    a_last_is_crc: assert property (@(posedge clk) disable iff (!rst_n)
        fire && sts.pos_last |-> (cmd.sel == SEL_CRC))
        else $error("last report byte is not the crc");

    a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        batch_reg <= BATCH_W'(LEDS_PER_REPORT))
        else $error("colour batch overran the report");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(LED_CAP))
        else $error("led count passed the maximum");

    a_frame_done_closes_report: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (lane == 3'd7) && sts.pos_last && cmd.end_frame
        |=> word_valid_reg && word_reg.frame_done && word_reg.report_done)
        else $error("end report word lost its flags");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking bench for led_strip_report_framer_crc8, with random idling on both channels
// builds its own expected report words from the colour stream; depends on lsrf_pkg and the rtl
`timescale 1ns / 1ps

module tb;

    import lsrf_pkg::*;

    localparam int TARGET_ITEMS = 380;
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_GUARD = 100000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item = '0;
    logic word_valid;
    logic word_ready = 1'b0;
    word_t word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;

    led_strip_report_framer_crc8 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    // framer state as the bench sees it
    logic [LIMIT_W-1:0] led_limit = LIMIT_RESET;
    logic [63:0] word_acc = '0;
    logic [POS_W-1:0] byte_pos = '0;
    logic [7:0] crc_acc = '0;
    logic [LIMIT_W-1:0] led_total = '0;
    int batch_fill = 0;
    bit frame_open = 1'b0;

    item_t pending_items[$];
    word_t expected_words[$];

    int errors = 0;
    int items_taken = 0;
    int useful_items = 0;
    int words_seen = 0;
    int reports_seen = 0;
    int frames_seen = 0;
    int cfg_writes = 0;
    bit calm = 1'b0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic int draw_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // bit-serial crc-8, poly 0x07, msb first
    function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ d[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input bit with_crc, input bit last_frame);
        word_t w;
        word_acc[8*byte_pos[2:0] +: 8] = b;
        if (with_crc)
            crc_acc = crc8_next(crc_acc, b);
        if (byte_pos[2:0] == 3'd7)
        begin
            w.report_word = word_acc;
            w.report_done = (byte_pos == CRC_POS);
            w.frame_done = (byte_pos == CRC_POS) && last_frame;
            expected_words.insert(expected_words.size(), w);
            word_acc = '0;
        end
        byte_pos = byte_pos + POS_W'(1);
    endfunction

    function automatic void close_report(input bit last_frame);
        while (byte_pos < CRC_POS)
            push_byte(8'h00, 1'b1, last_frame);
        push_byte(crc_acc, 1'b0, last_frame);
        crc_acc = '0;
        byte_pos = '0;
        word_acc = '0;
    endfunction

    function automatic void frame_item(input item_t it);
        int cap;
        cap = (led_limit > LED_CAP_DEFAULT) ? LED_CAP_DEFAULT : int'(led_limit);
        if (it.op == OP_COLOR)
        begin
            frame_open = 1'b1;
            if (led_total < cap)
            begin
                if (batch_fill == 0)
                begin
                    push_byte(REPORT_CMD, 1'b1, 1'b0);
                    push_byte(led_total[7:0], 1'b1, 1'b0);
                    push_byte({5'b0, led_total[10:8]}, 1'b1, 1'b0);
                end
                push_byte(it.green, 1'b1, 1'b0);
                push_byte(it.red, 1'b1, 1'b0);
                push_byte(it.blue, 1'b1, 1'b0);
                led_total++;
                batch_fill++;
                useful_items++;
                if (batch_fill == LEDS_PER_REPORT)
                begin
                    close_report(1'b0);
                    batch_fill = 0;
                end
            end
        end
        else if (frame_open)
        begin
            // flush a part-filled report, then the end report
            if (batch_fill > 0)
                close_report(1'b0);
            push_byte(REPORT_CMD, 1'b1, 1'b1);
            push_byte(END_MARK, 1'b1, 1'b1);
            push_byte(END_MARK, 1'b1, 1'b1);
            push_byte(led_total[7:0], 1'b1, 1'b1);
            push_byte({5'b0, led_total[10:8]}, 1'b1, 1'b1);
            close_report(1'b1);
            led_total = '0;
            batch_fill = 0;
            frame_open = 1'b0;
            useful_items++;
        end
    endfunction

    // sender
    item_t next_item = '0;
    bit holding = 1'b0;
    int hold_off = 0;
    bit valid_next;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            holding = 1'b0;
            hold_off = 0;
        end
        else
        begin
            valid_next = item_valid;
            if (item_valid && item_ready)
            begin
                frame_item(item);
                items_taken++;
                valid_next = 1'b0;
            end
            if (!valid_next && !holding && pending_items.size() > 0)
            begin
                next_item = pending_items.pop_front();
                holding = 1'b1;
                hold_off = draw_gap();
            end
            if (!valid_next && holding)
            begin
                if (hold_off == 0)
                begin
                    item <= next_item;
                    valid_next = 1'b1;
                    holding = 1'b0;
                end
                else
                begin
                    hold_off--;
                end
            end
            item_valid <= valid_next;
        end
    end

    // receiver
    int stall = 0;
    word_t want;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            word_ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (word_valid && word_ready)
            begin
                words_seen++;
                if (word.report_done)
                    reports_seen++;
                if (word.frame_done)
                    frames_seen++;
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat %h", word.report_word));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (word.report_word !== want.report_word)
                        report_mismatch($sformatf("report_word %h, wanted %h",
                                                  word.report_word, want.report_word));
                    if (word.report_done !== want.report_done)
                        report_mismatch($sformatf("report_done %b, wanted %b",
                                                  word.report_done, want.report_done));
                    if (word.frame_done !== want.frame_done)
                        report_mismatch($sformatf("frame_done %b, wanted %b",
                                                  word.frame_done, want.frame_done));
                end
                stall = draw_gap();
            end
            if (stall > 0)
            begin
                stall--;
                word_ready <= 1'b0;
            end
            else
            begin
                word_ready <= 1'b1;
            end
        end
    end

    task automatic queue_colour(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        item_t it;
        it.op = OP_COLOR;
        it.red = r;
        it.green = g;
        it.blue = b;
        pending_items.insert(pending_items.size(), it);
    endtask

    // colour fields on an end item carry noise
    task automatic queue_end();
        item_t it;
        it.op = OP_END;
        it.red = 8'($urandom_range(0, 255));
        it.green = 8'($urandom_range(0, 255));
        it.blue = 8'($urandom_range(0, 255));
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_frame(input int leds, input bit closed);
        for (int i = 0; i < leds; i++)
            queue_colour(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
        if (closed)
            queue_end();
    endtask

    // wait for the block to go quiet: every queued item taken and every expected beat arrived
    task automatic settle();
        int guard;
        guard = 0;
        while ((pending_items.size() != 0 || holding || item_valid ||
                expected_words.size() != 0) && guard < DRAIN_GUARD) begin
            @(posedge clk);
            guard++;
        end
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", expected_words.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        led_limit = v;
        cfg_writes++;
    endtask

    logic [LIMIT_W-1:0] limit_picks[8] = '{11'd20, 11'd21, 11'd19, 11'd2047,
                                           11'd0, 11'd1, 11'd1024, 11'd40};

    initial begin
        int p;
        int pick;
        bit long_done;
        logic [LIMIT_W-1:0] v;
        p = 0;
        long_done = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default limit: empty end, extreme colours, partial report flush
        calm = 1'b1;
        queue_end();
        queue_colour(8'hFF, 8'h00, 8'hFF);
        queue_colour(8'h00, 8'hFF, 8'h00);
        queue_end();
        queue_end();
        settle();

        // nothing accepted, but the frame still gets an end report
        write_limit(11'd0);
        queue_colour(8'hFF, 8'hFF, 8'hFF);
        queue_end();
        settle();

        // colours past the limit are dropped
        calm = 1'b0;
        write_limit(11'd3);
        queue_frame(5, 1'b1);
        settle();

        // limit lowered while a frame is open
        write_limit(11'd2047);
        queue_colour(8'h5A, 8'hA5, 8'h3C);
        queue_colour(8'hC3, 8'h0F, 8'hF0);
        settle();
        write_limit(11'd1);
        queue_colour(8'h12, 8'h34, 8'h56);
        queue_end();
        settle();

        while (items_taken < TARGET_ITEMS) begin
            if (p < 8)
                v = limit_picks[p];
            else if ($urandom_range(0, 3) == 0)
                v = LIMIT_W'($urandom_range(0, 2047));
            else
                v = LIMIT_W'($urandom_range(0, 60));
            write_limit(v);
            calm = ($urandom_range(0, 3) == 0);
            if (v == 11'd2047 && !long_done)
            begin
                // long enough for the offset high byte to move
                queue_frame(280, 1'b1);
                long_done = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(1, 3)) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        queue_frame($urandom_range(0, 45), 1'b1);
                    else if (pick < 90)
                        queue_end();
                    else
                        queue_frame($urandom_range(1, 25), 1'b0);
                end
            end
            settle();
            p++;
        end

        queue_end();
        settle();

        $display("%0d items taken (%0d of them framed), %0d limit writes",
                 items_taken, useful_items, cfg_writes);
        $display("%0d beats checked, %0d reports, %0d frame ends",
                 words_seen, reports_seen, frames_seen);
        if (errors == 0)
            $display("** led_strip_report_framer_crc8: PASSED **");
        else
            $display("** led_strip_report_framer_crc8: FAILED **");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout at %0t", $realtime);
        $display("** led_strip_report_framer_crc8: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
design/lsrf_pkg.sv
design/lsrf_ctrl.sv
design/lsrf_datapath.sv
design/led_strip_report_framer_crc8.sv
tb/tb.sv
